[rtl/nso_pkg.sv]
// ----------------------------------------------------------------------------
// nso_pkg
// shared types, constants and saturation helpers for the state observer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nso_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int DATA_W      = 32;
    localparam int ERR_W       = 33;
    localparam int STEP_W      = 17;
    localparam int GAIN_W      = 24;
    localparam int OPND_W      = 48;
    localparam int MUL_DIGIT_W = 8;
    localparam int MUL_DIGITS  = 3;
    localparam int DIGIT_IDX_W = 2;
    localparam int PP_W        = OPND_W + MUL_DIGIT_W + 1;
    localparam int ACC_W       = 72;
    localparam int SUM_W       = 73;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic signed [SUM_W-1:0] INNER_HI = 73'sd35184372088831;
    localparam logic signed [SUM_W-1:0] INNER_LO = -73'sd35184372088832;
    localparam logic signed [SUM_W-1:0] SAT_HI   = 73'sd2147483647;
    localparam logic signed [SUM_W-1:0] SAT_LO   = -73'sd2147483648;

    localparam logic [STEP_W-1:0]        RST_STEP_SIZE = 17'd655;
    localparam logic [GAIN_W-1:0]        RST_GAIN_ONE  = 24'd6553600;
    localparam logic [GAIN_W-1:0]        RST_GAIN_TWO  = 24'd13107200;
    localparam logic [STEP_W-1:0]        RST_THRESHOLD = 17'd655;
    localparam logic [GAIN_W-1:0]        RST_SLOPE     = 24'd655360;
    localparam logic signed [DATA_W-1:0] RST_INIT_POS  = 32'sd19661;
    localparam logic signed [DATA_W-1:0] RST_INIT_RATE = 32'sd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_SIZE,
        REG_GAIN_ONE,
        REG_GAIN_TWO,
        REG_THRESHOLD,
        REG_SLOPE,
        REG_INIT_POS,
        REG_INIT_RATE
    } cfg_reg_t;

    typedef struct packed {
        logic [STEP_W-1:0]        step_size;
        logic [GAIN_W-1:0]        gain_one;
        logic [GAIN_W-1:0]        gain_two;
        logic [STEP_W-1:0]        threshold;
        logic [GAIN_W-1:0]        slope;
        logic signed [DATA_W-1:0] init_pos;
        logic signed [DATA_W-1:0] init_rate;
    } nso_cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_G1_MUL,
        S_INNER,
        S_H1_MUL,
        S_DPOS,
        S_SQRT,
        S_ROOT,
        S_LIN_MUL,
        S_LIN_POST,
        S_G2_MUL,
        S_CORR,
        S_H2_MUL,
        S_DRATE,
        S_OUT
    } ctrl_state_t;

    typedef enum logic {
        A_ERR,
        A_OPND
    } a_sel_t;

    typedef enum logic [1:0] {
        B_STEP,
        B_GAIN_ONE,
        B_GAIN_TWO,
        B_SLOPE
    } b_sel_t;

    typedef enum logic [2:0] {
        POST_NONE,
        POST_INNER,
        POST_DPOS,
        POST_FAL,
        POST_CORR,
        POST_DRATE,
        POST_ROOT
    } post_op_t;

    typedef struct packed {
        logic                   load;
        logic                   mul_step;
        logic                   mul_first;
        logic [DIGIT_IDX_W-1:0] digit;
        a_sel_t                 a_sel;
        b_sel_t                 b_sel;
        post_op_t               post;
        logic                   sqrt_init;
        logic                   sqrt_step;
        logic                   out_load;
    } nso_cmd_t;

    typedef struct packed {
        logic e_big;
        logic out_free;
    } nso_status_t;

    function automatic logic signed [OPND_W-1:0] clamp_inner(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [OPND_W-1:0] r;
        if (v > INNER_HI)
            r = INNER_HI[OPND_W-1:0];
        else if (v < INNER_LO)
            r = INNER_LO[OPND_W-1:0];
        else
            r = v[OPND_W-1:0];
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [DATA_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[DATA_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[DATA_W-1:0];
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

[rtl/nso_cfg.sv]
// ----------------------------------------------------------------------------
// nso_cfg
// configuration register file, masked to field widths on write
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nso_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [nso_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nso_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output nso_pkg::nso_cfg_t                cfg
);

    nso_pkg::nso_cfg_t cfg_reg;
    nso_pkg::nso_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (nso_pkg::cfg_reg_t'(cfg_index))
                nso_pkg::REG_STEP_SIZE: cfg_next.step_size = cfg_wdata[nso_pkg::STEP_W-1:0];
                nso_pkg::REG_GAIN_ONE:  cfg_next.gain_one  = cfg_wdata[nso_pkg::GAIN_W-1:0];
                nso_pkg::REG_GAIN_TWO:  cfg_next.gain_two  = cfg_wdata[nso_pkg::GAIN_W-1:0];
                nso_pkg::REG_THRESHOLD: cfg_next.threshold = cfg_wdata[nso_pkg::STEP_W-1:0];
                nso_pkg::REG_SLOPE:     cfg_next.slope     = cfg_wdata[nso_pkg::GAIN_W-1:0];
                nso_pkg::REG_INIT_POS:  cfg_next.init_pos  = cfg_wdata[nso_pkg::DATA_W-1:0];
                nso_pkg::REG_INIT_RATE: cfg_next.init_rate = cfg_wdata[nso_pkg::DATA_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size <= nso_pkg::RST_STEP_SIZE;
            cfg_reg.gain_one  <= nso_pkg::RST_GAIN_ONE;
            cfg_reg.gain_two  <= nso_pkg::RST_GAIN_TWO;
            cfg_reg.threshold <= nso_pkg::RST_THRESHOLD;
            cfg_reg.slope     <= nso_pkg::RST_SLOPE;
            cfg_reg.init_pos  <= nso_pkg::RST_INIT_POS;
            cfg_reg.init_rate <= nso_pkg::RST_INIT_RATE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/nso_ctrl.sv]
// ----------------------------------------------------------------------------
// nso_ctrl
// sequencer: multiply digits, square root steps and post operations
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nso_ctrl #(
    parameter int SQRT_STEPS = 25
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  nso_pkg::nso_status_t status,
    output nso_pkg::nso_cmd_t    cmd
);

    localparam int SCNT_W = $clog2(SQRT_STEPS);
    localparam logic [nso_pkg::DIGIT_IDX_W-1:0] MUL_LAST =
        nso_pkg::DIGIT_IDX_W'(nso_pkg::MUL_DIGITS - 1);
    localparam logic [SCNT_W-1:0] SQRT_LAST = SCNT_W'(SQRT_STEPS - 1);

    nso_pkg::ctrl_state_t state_reg, state_next;
    logic [nso_pkg::DIGIT_IDX_W-1:0] dcnt_reg, dcnt_next;
    logic [SCNT_W-1:0]               scnt_reg, scnt_next;
    logic                            digit_done;

    assign digit_done = (dcnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nso_pkg::S_IDLE;
            dcnt_reg  <= MUL_LAST;
            scnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dcnt_reg  <= dcnt_next;
            scnt_reg  <= scnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        dcnt_next     = MUL_LAST;
        scnt_next     = scnt_reg;
        s_tready      = 1'b0;
        cmd           = '0;
        cmd.a_sel     = nso_pkg::A_ERR;
        cmd.b_sel     = nso_pkg::B_STEP;
        cmd.post      = nso_pkg::POST_NONE;
        cmd.digit     = dcnt_reg;
        cmd.mul_first = (dcnt_reg == MUL_LAST);

        unique case (state_reg)
            nso_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = nso_pkg::S_G1_MUL;
                end
            end
            nso_pkg::S_G1_MUL:
            begin
                cmd.mul_step = 1'b1;
                cmd.a_sel    = nso_pkg::A_ERR;
                cmd.b_sel    = nso_pkg::B_GAIN_ONE;
                if (digit_done)
                    state_next = nso_pkg::S_INNER;
                else
                    dcnt_next = dcnt_reg - 1'b1;
            end
            nso_pkg::S_INNER:
            begin
                cmd.post   = nso_pkg::POST_INNER;
                state_next = nso_pkg::S_H1_MUL;
            end
            nso_pkg::S_H1_MUL:
            begin
                cmd.mul_step = 1'b1;
                cmd.a_sel    = nso_pkg::A_OPND;
                cmd.b_sel    = nso_pkg::B_STEP;
                if (digit_done)
                    state_next = nso_pkg::S_DPOS;
                else
                    dcnt_next = dcnt_reg - 1'b1;
            end
            nso_pkg::S_DPOS:
            begin
                cmd.post = nso_pkg::POST_DPOS;
                if (status.e_big)
                begin
                    cmd.sqrt_init = 1'b1;
                    scnt_next     = SQRT_LAST;
                    state_next    = nso_pkg::S_SQRT;
                end
                else
                begin
                    state_next = nso_pkg::S_LIN_MUL;
                end
            end
            nso_pkg::S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (scnt_reg == '0)
                    state_next = nso_pkg::S_ROOT;
                else
                    scnt_next = scnt_reg - 1'b1;
            end
            nso_pkg::S_ROOT:
            begin
                cmd.post   = nso_pkg::POST_ROOT;
                state_next = nso_pkg::S_G2_MUL;
            end
            nso_pkg::S_LIN_MUL:
            begin
                cmd.mul_step = 1'b1;
                cmd.a_sel    = nso_pkg::A_ERR;
                cmd.b_sel    = nso_pkg::B_SLOPE;
                if (digit_done)
                    state_next = nso_pkg::S_LIN_POST;
                else
                    dcnt_next = dcnt_reg - 1'b1;
            end
            nso_pkg::S_LIN_POST:
            begin
                cmd.post   = nso_pkg::POST_FAL;
                state_next = nso_pkg::S_G2_MUL;
            end
            nso_pkg::S_G2_MUL:
            begin
                cmd.mul_step = 1'b1;
                cmd.a_sel    = nso_pkg::A_OPND;
                cmd.b_sel    = nso_pkg::B_GAIN_TWO;
                if (digit_done)
                    state_next = nso_pkg::S_CORR;
                else
                    dcnt_next = dcnt_reg - 1'b1;
            end
            nso_pkg::S_CORR:
            begin
                cmd.post   = nso_pkg::POST_CORR;
                state_next = nso_pkg::S_H2_MUL;
            end
            nso_pkg::S_H2_MUL:
            begin
                cmd.mul_step = 1'b1;
                cmd.a_sel    = nso_pkg::A_OPND;
                cmd.b_sel    = nso_pkg::B_STEP;
                if (digit_done)
                    state_next = nso_pkg::S_DRATE;
                else
                    dcnt_next = dcnt_reg - 1'b1;
            end
            nso_pkg::S_DRATE:
            begin
                cmd.post   = nso_pkg::POST_DRATE;
                state_next = nso_pkg::S_OUT;
            end
            nso_pkg::S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = nso_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nso_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[rtl/nso_dp.sv]
// ----------------------------------------------------------------------------
// nso_dp
// datapath: estimates, digit-serial multiplier, bit-serial square root,
// post operations with clamping, output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nso_dp #(
    parameter int FRAC_BITS  = nso_pkg::FRAC_BITS_DEF,
    parameter int SQRT_STEPS = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  nso_pkg::nso_cfg_t                 cfg,
    input  nso_pkg::nso_cmd_t                 cmd,
    output nso_pkg::nso_status_t              status,
    input  logic signed [nso_pkg::DATA_W-1:0] in_measurement,
    input  logic                              in_load_initial,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [nso_pkg::DATA_W-1:0]        out_position,
    output logic [nso_pkg::DATA_W-1:0]        out_rate
);

    localparam int RAD_W = 2 * SQRT_STEPS;
    localparam int REM_W = SQRT_STEPS + 2;
    localparam int TRY_W = SQRT_STEPS + 4;

    logic signed [nso_pkg::DATA_W-1:0] pos_reg, pos_next;
    logic signed [nso_pkg::DATA_W-1:0] rate_reg, rate_next;
    logic signed [nso_pkg::ERR_W-1:0]  err_reg, err_next;
    logic signed [nso_pkg::OPND_W-1:0] opnd_reg, opnd_next;
    logic signed [nso_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [RAD_W-1:0]                  rad_reg, rad_next;
    logic [REM_W-1:0]                  rem_reg, rem_next;
    logic [SQRT_STEPS-1:0]             root_reg, root_next;
    logic                              out_valid_reg, out_valid_next;
    logic [nso_pkg::DATA_W-1:0]        out_pos_reg, out_rate_reg;

    logic signed [nso_pkg::DATA_W-1:0] base_pos;
    logic [nso_pkg::ERR_W-1:0]         err_mag;
    logic signed [nso_pkg::OPND_W-1:0] a_op;
    logic [nso_pkg::GAIN_W-1:0]        b_op;
    logic [nso_pkg::MUL_DIGIT_W-1:0]   b_digit;
    logic signed [nso_pkg::PP_W-1:0]   pp;
    logic signed [nso_pkg::ACC_W-1:0]  shifted;
    logic signed [nso_pkg::SUM_W-1:0]  shifted_x;
    logic [TRY_W-1:0]                  rem_sh, trial;
    logic signed [nso_pkg::OPND_W-1:0] root_x;

    // error magnitude, 33 bits unsigned so that -2^32 still fits
    assign err_mag = err_reg[nso_pkg::ERR_W-1] ? (~err_reg + 1'b1) : err_reg;

    assign status.e_big    = (err_mag > {{(nso_pkg::ERR_W-nso_pkg::STEP_W){1'b0}}, cfg.threshold});
    assign status.out_free = !out_valid_reg || out_ready;

    // shared 48 x 8 multiplier, most significant digit first
    always_comb
    begin
        case (cmd.a_sel)
            nso_pkg::A_ERR: a_op = {{(nso_pkg::OPND_W-nso_pkg::ERR_W){err_reg[nso_pkg::ERR_W-1]}},
                                    err_reg};
            default:        a_op = opnd_reg;
        endcase
        case (cmd.b_sel)
            nso_pkg::B_STEP:     b_op = {{(nso_pkg::GAIN_W-nso_pkg::STEP_W){1'b0}}, cfg.step_size};
            nso_pkg::B_GAIN_ONE: b_op = cfg.gain_one;
            nso_pkg::B_GAIN_TWO: b_op = cfg.gain_two;
            default:             b_op = cfg.slope;
        endcase
    end

    assign b_digit = b_op[cmd.digit*nso_pkg::MUL_DIGIT_W +: nso_pkg::MUL_DIGIT_W];
    assign pp      = $signed({{(nso_pkg::PP_W-nso_pkg::OPND_W){a_op[nso_pkg::OPND_W-1]}}, a_op})
                   * $signed({{(nso_pkg::PP_W-nso_pkg::MUL_DIGIT_W){1'b0}}, b_digit});

    assign shifted   = acc_reg >>> FRAC_BITS;
    assign shifted_x = {shifted[nso_pkg::ACC_W-1], shifted};

    // restoring square root, one root bit per step
    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign root_x = {{(nso_pkg::OPND_W-SQRT_STEPS){1'b0}}, root_reg};

    assign base_pos = in_load_initial ? cfg.init_pos : pos_reg;

    always_comb
    begin
        pos_next  = pos_reg;
        rate_next = rate_reg;
        err_next  = err_reg;
        opnd_next = opnd_reg;
        acc_next  = acc_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;

        if (cmd.load)
        begin
            err_next = {base_pos[nso_pkg::DATA_W-1], base_pos}
                     - {in_measurement[nso_pkg::DATA_W-1], in_measurement};
            if (in_load_initial)
            begin
                pos_next  = cfg.init_pos;
                rate_next = cfg.init_rate;
            end
        end

        if (cmd.mul_step)
        begin
            acc_next = (cmd.mul_first ? '0 : (acc_reg <<< nso_pkg::MUL_DIGIT_W))
                     + {{(nso_pkg::ACC_W-nso_pkg::PP_W){pp[nso_pkg::PP_W-1]}}, pp};
        end

        if (cmd.sqrt_init)
        begin
            rad_next  = RAD_W'(err_mag) << FRAC_BITS;
            rem_next  = '0;
            root_next = '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_next = rad_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[SQRT_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem_sh);
                root_next = {root_reg[SQRT_STEPS-2:0], 1'b0};
            end
        end

        case (cmd.post)
            nso_pkg::POST_INNER:
                opnd_next = nso_pkg::clamp_inner(
                    {{(nso_pkg::SUM_W-nso_pkg::DATA_W){rate_reg[nso_pkg::DATA_W-1]}}, rate_reg}
                    - shifted_x);
            nso_pkg::POST_DPOS:
                pos_next = nso_pkg::sat32(
                    {{(nso_pkg::SUM_W-nso_pkg::DATA_W){pos_reg[nso_pkg::DATA_W-1]}}, pos_reg}
                    + shifted_x);
            nso_pkg::POST_FAL:
                opnd_next = shifted[nso_pkg::OPND_W-1:0];
            nso_pkg::POST_CORR:
                opnd_next = nso_pkg::clamp_inner(shifted_x);
            nso_pkg::POST_DRATE:
                rate_next = nso_pkg::sat32(
                    {{(nso_pkg::SUM_W-nso_pkg::DATA_W){rate_reg[nso_pkg::DATA_W-1]}}, rate_reg}
                    - shifted_x);
            nso_pkg::POST_ROOT:
                opnd_next = err_reg[nso_pkg::ERR_W-1] ? -root_x : root_x;
            default:
                opnd_next = opnd_next;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= nso_pkg::RST_INIT_POS;
            rate_reg      <= nso_pkg::RST_INIT_RATE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            rate_reg      <= rate_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg  <= err_next;
        opnd_reg <= opnd_next;
        acc_reg  <= acc_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        if (cmd.out_load)
        begin
            out_pos_reg  <= pos_reg;
            out_rate_reg <= rate_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_position = out_pos_reg;
    assign out_rate     = out_rate_reg;

endmodule

[rtl/nonlinear_state_observer.sv]
// ----------------------------------------------------------------------------
// nonlinear_state_observer
// an update takes the root path when |error| is above fal_threshold and runs longer
//   there than inside the linear zone; a new input transaction is taken only in idle
// the bit-serial root (one bit per cycle) and four 3-digit products (five inside the
//   linear zone) on one shared 48 x 8 multiplier set how long each update runs
// reset: async active low; registers to defaults, estimates to init defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nonlinear_state_observer #(
    parameter int FRAC_BITS = nso_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port, index follows the register list
    input  logic                                 cfg_wr_en,
    input  logic [nso_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [nso_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [nso_pkg::DATA_W-1:0]           s_tdata,   // [31:0] measurement
    input  logic                                 s_tuser,   // [0] load_initial
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [2*nso_pkg::DATA_W-1:0]         m_tdata    // [31:0] position_estimate,
                                                            // [63:32] rate_estimate
);

    // root of |e| << FRAC_BITS: radicand padded to an even bit count
    localparam int SQRT_STEPS = (nso_pkg::ERR_W + FRAC_BITS + 1) / 2;

    nso_pkg::nso_cfg_t    cfg;
    nso_pkg::nso_cmd_t    cmd;
    nso_pkg::nso_status_t status;
    logic [nso_pkg::DATA_W-1:0] out_position;
    logic [nso_pkg::DATA_W-1:0] out_rate;

    // register file; the user must write it only between transactions, the block does not enforce this
    nso_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // sequencer: accepts one transaction in idle, walks the update, then
    // waits for room in the output register before returning to idle
    nso_ctrl #(
        .SQRT_STEPS (SQRT_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: error, position update, fal (root or linear), rate update;
    // the output register lets a finished result wait while the next input
    // transaction is already taken
    nso_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .SQRT_STEPS (SQRT_STEPS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .status          (status),
        .in_measurement  (s_tdata),
        .in_load_initial (s_tuser),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_position    (out_position),
        .out_rate        (out_rate)
    );

    // position in the low word, rate in the high word
    assign m_tdata = {out_rate, out_position};

endmodule

[rtl/nso_checker.sv]
// ----------------------------------------------------------------------------
// nso_checker
// port-level checks on the observer streams, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nso_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [2*nso_pkg::DATA_W-1:0]       m_tdata
);

    // a stalled result keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one transaction in flight: input closes right after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while busy");

    // no result may appear too early after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid) ##1 !$rose(m_tvalid))
        else $error("result appeared too early");

endmodule

bind nonlinear_state_observer nso_checker u_nso_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
